[sv/scdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scdp_pkg;

    localparam int MAX_SEEDS_DEF = 64;

    localparam logic [7:0] NO_SEED_DIST = 8'd255;
    localparam int         WEIGHT_SCALE = 10;

    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_ADD_SEED = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    localparam logic [2:0] ST_PIXEL_OK  = 3'd0;
    localparam logic [2:0] ST_BOTH_ZERO = 3'd1;
    localparam logic [2:0] ST_STORED    = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEED,
        S_CLEAR,
        S_SCAN,
        S_DIV_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_load;
        logic seed_wr;
        logic clear;
        logic scan;
        logic div_load;
        logic div_step;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       scan_done;
        logic       both_zero;
        logic       div_last;
        logic       out_free;
    } t_dp_stat;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

[sv/scdp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface scdp_px_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
    logic       is_foreground;

    modport source (output valid, cmd, chan_blue, chan_green, chan_red, is_foreground,
                    input ready);
    modport sink   (input valid, cmd, chan_blue, chan_green, chan_red, is_foreground,
                    output ready);
endinterface

interface scdp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] dist_fore;
    logic [7:0] dist_back;
    logic [3:0] weight_source;
    logic [3:0] weight_sink;
    logic [2:0] status;

    modport source (output valid, dist_fore, dist_back, weight_source, weight_sink, status,
                    input ready);
    modport sink   (input valid, dist_fore, dist_back, weight_source, weight_sink, status,
                    output ready);
endinterface

`default_nettype wire

[sv/scdp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module scdp_ram #(
    parameter  int WIDTH  = 25,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/scdp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module scdp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  scdp_pkg::t_dp_stat   i_stat,
    output scdp_pkg::t_ctrl_cmd  o_cmd
);

    import scdp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_CLASSIFY: n_state = S_SCAN;
                    CMD_ADD_SEED: n_state = S_SEED;
                    CMD_CLEAR:    n_state = S_CLEAR;
                    default:      n_state = S_IDLE;
                endcase
            end
            S_SEED:     n_state = S_EMIT;
            S_CLEAR:    n_state = S_EMIT;
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_DIV_LOAD;
            end
            S_DIV_LOAD: n_state = i_stat.both_zero ? S_EMIT : S_DIV;
            S_DIV: begin
                if (i_stat.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd          = '0;
        o_cmd.in_load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.seed_wr  = (r_state == S_SEED);
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.div_load = (r_state == S_DIV_LOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.emit     = (r_state == S_EMIT) && i_stat.out_free;
    end

endmodule

`default_nettype wire

[sv/scdp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module scdp_dp #(
    parameter int MAX_SEEDS = scdp_pkg::MAX_SEEDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    scdp_px_if.sink             i_px,
    scdp_res_if.source          o_res,
    input  scdp_pkg::t_ctrl_cmd i_cmd,
    output scdp_pkg::t_dp_stat  o_stat
);

    import scdp_pkg::*;

    localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CW = $clog2(MAX_SEEDS + 1);

    logic [1:0]    r_cmd;
    logic [7:0]    r_b;
    logic [7:0]    r_g;
    logic [7:0]    r_r;
    logic          r_fg;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic [7:0]    r_df;
    logic [7:0]    r_db;
    logic [11:0]   r_rem_s;
    logic [11:0]   r_rem_k;
    logic [11:0]   r_den;
    logic [3:0]    r_ws;
    logic [3:0]    r_wk;
    logic [1:0]    r_step;
    logic [2:0]    r_status;
    logic          r_ovalid;
    logic [7:0]    r_o_df;
    logic [7:0]    r_o_db;
    logic [3:0]    r_o_ws;
    logic [3:0]    r_o_wk;
    logic [2:0]    r_o_status;

    logic          full;
    logic          issue;
    logic          ram_we;
    logic [24:0]   ram_q;
    logic [7:0]    cheb_d;
    logic [7:0]    d_b;
    logic [7:0]    d_g;
    logic [7:0]    d_r;
    logic [8:0]    dsum;
    logic          ge_s;
    logic          ge_k;
    logic          out_free;

    assign full     = (r_count == CW'(MAX_SEEDS));
    assign issue    = i_cmd.scan && (r_idx != r_count);
    assign ram_we   = i_cmd.seed_wr && !full;
    assign out_free = !r_ovalid || o_res.ready;

    // entry layout: {fg, red, green, blue}
    scdp_ram #(
        .WIDTH (25),
        .DEPTH (MAX_SEEDS)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_fg, r_r, r_g, r_b}),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        d_b    = abs_diff8(r_b, ram_q[7:0]);
        d_g    = abs_diff8(r_g, ram_q[15:8]);
        d_r    = abs_diff8(r_r, ram_q[23:16]);
        cheb_d = d_b;
        if (d_g > cheb_d) cheb_d = d_g;
        if (d_r > cheb_d) cheb_d = d_r;
        dsum = {1'b0, r_df} + {1'b0, r_db};
        ge_s = (r_rem_s >= r_den);
        ge_k = (r_rem_k >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (ram_we) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_cmd <= i_px.cmd;
            r_b   <= i_px.chan_blue;
            r_g   <= i_px.chan_green;
            r_r   <= i_px.chan_red;
            r_fg  <= i_px.is_foreground;
            r_idx <= '0;
            r_df  <= NO_SEED_DIST;
            r_db  <= NO_SEED_DIST;
            r_ws  <= '0;
            r_wk  <= '0;
        end
        if (issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (r_rd_vld) begin
            if (ram_q[24]) begin
                if (cheb_d < r_df) r_df <= cheb_d;
            end else begin
                if (cheb_d < r_db) r_db <= cheb_d;
            end
        end
        if (i_cmd.seed_wr) begin
            r_df     <= '0;
            r_db     <= '0;
            r_status <= full ? ST_DROPPED : ST_STORED;
        end
        if (i_cmd.clear) begin
            r_df     <= '0;
            r_db     <= '0;
            r_status <= ST_CLEARED;
        end
        if (i_cmd.div_load) begin
            // 10*x as 8x + 2x; divisor aligned to quotient bit 3
            r_rem_s  <= {1'b0, r_db, 3'b000} + {3'b000, r_db, 1'b0};
            r_rem_k  <= {1'b0, r_df, 3'b000} + {3'b000, r_df, 1'b0};
            r_den    <= {dsum, 3'b000};
            r_step   <= 2'd3;
            r_status <= (dsum == 9'd0) ? ST_BOTH_ZERO : ST_PIXEL_OK;
        end
        if (i_cmd.div_step) begin
            r_ws    <= {r_ws[2:0], ge_s};
            r_wk    <= {r_wk[2:0], ge_k};
            r_rem_s <= ge_s ? (r_rem_s - r_den) : r_rem_s;
            r_rem_k <= ge_k ? (r_rem_k - r_den) : r_rem_k;
            r_den   <= {1'b0, r_den[11:1]};
            r_step  <= r_step - 2'd1;
        end
        if (i_cmd.emit) begin
            r_o_df     <= r_df;
            r_o_db     <= r_db;
            r_o_ws     <= r_ws;
            r_o_wk     <= r_wk;
            r_o_status <= r_status;
        end
    end

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.scan_done = (r_idx == r_count) && !r_rd_vld;
        o_stat.both_zero = (dsum == 9'd0);
        o_stat.div_last  = (r_step == 2'd0);
        o_stat.out_free  = out_free;
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.dist_fore     = r_o_df;
    assign o_res.dist_back     = r_o_db;
    assign o_res.weight_source = r_o_ws;
    assign o_res.weight_sink   = r_o_wk;
    assign o_res.status        = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEEDS))
        else $error("seed count beyond table depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || o_res.ready))
        else $error("result overwrites a pending transfer");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (({1'b0, r_o_ws} + {1'b0, r_o_wk}) <= 5'(WEIGHT_SCALE)))
        else $error("weights exceed scale");

    a_both_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_o_status == ST_BOTH_ZERO)) |->
        ((r_o_df == 8'd0) && (r_o_db == 8'd0) && (r_o_ws == 4'd0) && (r_o_wk == 4'd0)))
        else $error("zero-distance result carries nonzero fields");

endmodule

`default_nettype wire

[sv/seed_color_distance_prior.sv]
`timescale 1ns / 1ps
`default_nettype none

// Seed color distance prior. Each transfer on i_px carries a command: add a seed color
// (foreground or background) to a table of MAX_SEEDS entries, clear the table, or
// classify a pixel, which returns the least Chebyshev distance to each seed class (255
// for an empty class) and the prior weights 10*db/(df+db) and 10*df/(df+db); both
// weights are 0 with status 1 when both distances are zero. Every command except the
// unused code 3 gives exactly one transfer on o_res. One command is in flight at a time.
// A classify walks the seed RAM at one entry per cycle and then runs a four-step
// quotient loop, which is skipped when both distances are zero. A result that still
// waits on o_res holds the next one back until it is taken. The input is taken again
// while a result still waits on o_res. The seed table needs no clearing pass: only
// entries below the seed count are read.
module seed_color_distance_prior #(
    parameter int MAX_SEEDS = scdp_pkg::MAX_SEEDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scdp_px_if.sink     i_px,
    scdp_res_if.source  o_res
);

    import scdp_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;
    logic      in_ready;

    assign i_px.ready = in_ready;

    scdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_px.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    scdp_dp #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_px),
        .o_res   (o_res),
        .i_cmd   (ctrl_cmd),
        .o_stat  (dp_stat)
    );

endmodule

`default_nettype wire
